// File: sv/swkl_pkg.sv
// Shared types and constants of the stopwatch with key lockout.
`default_nettype none
package swkl_pkg;

  localparam int unsigned LimitWidth = 13;
  localparam int unsigned FramesWidth = 8;
  localparam int unsigned LockWidth = 9;
  localparam int unsigned ApbDataWidth = 32;
  localparam int unsigned ApbAddrWidth = 4;

  // Reset values of the configuration registers.
  localparam logic [LimitWidth-1:0] GreenReset = 13'd60;
  localparam logic [LimitWidth-1:0] YellowReset = 13'd90;
  localparam logic [LimitWidth-1:0] OrangeReset = 13'd180;
  localparam logic [FramesWidth-1:0] FramesReset = 8'd10;

  // Register word indexes (byte address is four times the index).
  typedef enum logic [1:0] {
    REG_GREEN  = 2'd0,
    REG_YELLOW = 2'd1,
    REG_ORANGE = 2'd2,
    REG_FRAMES = 2'd3
  } reg_idx_t;

  // Request operation codes; the fourth code is unused and ignored.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_FRAME = 2'd1,
    OP_CLICK = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ZONE_GREEN  = 2'd0,
    ZONE_YELLOW = 2'd1,
    ZONE_ORANGE = 2'd2,
    ZONE_RED    = 2'd3
  } zone_t;

  typedef struct packed {
    logic [LimitWidth-1:0]  green_limit_s;
    logic [LimitWidth-1:0]  yellow_limit_s;
    logic [LimitWidth-1:0]  orange_limit_s;
    logic [FramesWidth-1:0] lockout_frames;
  } cfg_t;

  typedef struct packed {
    logic [3:0] min_tens;
    logic [3:0] min_ones;
    logic [2:0] sec_tens;
    logic [3:0] sec_ones;
    logic [3:0] tenth_digit;
    logic [3:0] hundredth_digit;
    logic [1:0] color_zone;
    logic       running;
  } result_t;

endpackage
`default_nettype wire

// File: sv/swkl_regs.sv
// APB configuration registers of the stopwatch.
`default_nettype none
module swkl_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swkl_pkg::ApbAddrWidth-1:0]   paddr,
  input  logic [swkl_pkg::ApbDataWidth-1:0]   pwdata,
  output logic [swkl_pkg::ApbDataWidth-1:0]   prdata,
  output logic                                pready,
  output swkl_pkg::cfg_t                      cfg
);
  import swkl_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.green_limit_s  <= GreenReset;
      cfg.yellow_limit_s <= YellowReset;
      cfg.orange_limit_s <= OrangeReset;
      cfg.lockout_frames <= FramesReset;
    end else if (wr_en) begin
      case (idx)
        REG_GREEN:  cfg.green_limit_s  <= pwdata[LimitWidth-1:0];
        REG_YELLOW: cfg.yellow_limit_s <= pwdata[LimitWidth-1:0];
        REG_ORANGE: cfg.orange_limit_s <= pwdata[LimitWidth-1:0];
        REG_FRAMES: cfg.lockout_frames <= pwdata[FramesWidth-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GREEN:  prdata = {{(ApbDataWidth-LimitWidth){1'b0}}, cfg.green_limit_s};
      REG_YELLOW: prdata = {{(ApbDataWidth-LimitWidth){1'b0}}, cfg.yellow_limit_s};
      REG_ORANGE: prdata = {{(ApbDataWidth-LimitWidth){1'b0}}, cfg.orange_limit_s};
      REG_FRAMES: prdata = {{(ApbDataWidth-FramesWidth){1'b0}}, cfg.lockout_frames};
      default:    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/swkl_core.sv
// Stopwatch state: decimal time counters, run flag, key lockout and frame result.
`default_nettype none
module swkl_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic [1:0]        op,
  input  logic              key_down,
  input  swkl_pkg::cfg_t    cfg,
  output logic              push,
  output swkl_pkg::result_t result
);
  import swkl_pkg::*;

  // Time held as decimal digits: mm:ss.mmm
  typedef struct packed {
    logic [3:0] min_t;
    logic [3:0] min_o;
    logic [2:0] sec_t;
    logic [3:0] sec_o;
    logic [3:0] ms_h;
    logic [3:0] ms_t;
    logic [3:0] ms_o;
  } bcd_time_t;

  bcd_time_t            time_q, time_next;
  logic                 run_q, run_next;
  logic [LockWidth-1:0] lock_q, lock_next;

  // Frame intermediates
  bcd_time_t            time_key;
  logic                 run_key;
  logic [LockWidth-1:0] lock_key;
  logic [LockWidth-1:0] lock_inc;
  logic [6:0]           minutes;
  logic [LimitWidth-1:0] total_s;
  zone_t                zone;
  logic                 saturated;
  logic                 min_cap;

  assign saturated = time_q.min_t == 4'd9 && time_q.min_o == 4'd9 &&
                     time_q.sec_t == 3'd5 && time_q.sec_o == 4'd9 &&
                     time_q.ms_h == 4'd9 && time_q.ms_t == 4'd9 && time_q.ms_o == 4'd9;

  // Key handling within a frame, before the digits are formed.
  always_comb begin
    run_key  = run_q;
    time_key = time_q;
    lock_key = lock_q;
    if (lock_q == '0 && key_down) begin
      run_key  = !run_q;
      lock_key = {{(LockWidth-1){1'b0}}, 1'b1};
      if (!run_q) begin
        time_key = '0;
      end
    end
    lock_inc = lock_key;
    if (lock_key != '0) begin
      lock_inc = lock_key + 1'b1;
      if (lock_inc > {1'b0, cfg.lockout_frames}) begin
        lock_inc = '0;
      end
    end
  end

  // Elapsed whole seconds and colour zone of the frame.
  always_comb begin
    minutes = 7'(time_key.min_t * 4'd10) + 7'(time_key.min_o);
    total_s = LimitWidth'(minutes * 6'd60) + LimitWidth'(time_key.sec_t * 4'd10)
              + LimitWidth'(time_key.sec_o);
    if (total_s < cfg.green_limit_s) begin
      zone = ZONE_GREEN;
    end else if (total_s < cfg.yellow_limit_s) begin
      zone = ZONE_YELLOW;
    end else if (total_s < cfg.orange_limit_s) begin
      zone = ZONE_ORANGE;
    end else begin
      zone = ZONE_RED;
    end
    min_cap = time_key.min_t == 4'd9 && time_key.min_o == 4'd9;
  end

  always_comb begin
    time_next = time_q;
    run_next  = run_q;
    lock_next = lock_q;
    push      = 1'b0;
    if (in_fire) begin
      case (op)
        OP_TICK: begin
          if (run_q && !saturated) begin
            if (time_q.ms_o != 4'd9) begin
              time_next.ms_o = time_q.ms_o + 4'd1;
            end else begin
              time_next.ms_o = '0;
              if (time_q.ms_t != 4'd9) begin
                time_next.ms_t = time_q.ms_t + 4'd1;
              end else begin
                time_next.ms_t = '0;
                if (time_q.ms_h != 4'd9) begin
                  time_next.ms_h = time_q.ms_h + 4'd1;
                end else begin
                  time_next.ms_h = '0;
                  if (time_q.sec_o != 4'd9) begin
                    time_next.sec_o = time_q.sec_o + 4'd1;
                  end else begin
                    time_next.sec_o = '0;
                    if (time_q.sec_t != 3'd5) begin
                      time_next.sec_t = time_q.sec_t + 3'd1;
                    end else begin
                      time_next.sec_t = '0;
                      if (time_q.min_o != 4'd9) begin
                        time_next.min_o = time_q.min_o + 4'd1;
                      end else begin
                        time_next.min_o = '0;
                        time_next.min_t = time_q.min_t + 4'd1;
                      end
                    end
                  end
                end
              end
            end
          end
        end
        OP_FRAME: begin
          push      = 1'b1;
          lock_next = lock_inc;
          if (min_cap) begin
            run_next  = 1'b0;
            time_next = '0;
          end else begin
            run_next  = run_key;
            time_next = time_key;
          end
        end
        OP_CLICK: begin
          run_next = !run_q;
          if (!run_q) begin
            time_next = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result.min_tens        = time_key.min_t;
    result.min_ones        = time_key.min_o;
    result.sec_tens        = time_key.sec_t;
    result.sec_ones        = time_key.sec_o;
    result.tenth_digit     = time_key.ms_h;
    result.hundredth_digit = time_key.ms_t;
    result.color_zone      = zone;
    result.running         = run_key && !min_cap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_q <= '0;
      run_q  <= 1'b0;
      lock_q <= '0;
    end else begin
      time_q <= time_next;
      run_q  <= run_next;
      lock_q <= lock_next;
    end
  end

  a_digits_decimal: assert property (@(posedge clk) disable iff (rst)
    time_q.ms_o <= 4'd9 && time_q.ms_t <= 4'd9 && time_q.ms_h <= 4'd9 &&
    time_q.sec_o <= 4'd9 && time_q.sec_t <= 3'd5 &&
    time_q.min_o <= 4'd9 && time_q.min_t <= 4'd9)
    else $error("stopwatch digit out of decimal range");

  // The limit may be lowered while a lockout runs, so only the largest
  // setting bounds the count.
  a_lock_bound: assert property (@(posedge clk) disable iff (rst)
    lock_q <= {1'b0, {FramesWidth{1'b1}}})
    else $error("lockout count beyond its largest setting");

  a_cap_stops: assert property (@(posedge clk) disable iff (rst)
    (push && min_cap) |=> (!run_q && time_q == '0))
    else $error("minute ninety-nine frame did not stop and clear");

endmodule
`default_nettype wire

// File: sv/swkl_outbuf.sv
// Result register with a skid stage for the frame results.
`default_nettype none
module swkl_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  swkl_pkg::result_t push_data,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output swkl_pkg::result_t out_data
);
  import swkl_pkg::*;

  logic    skid_valid, skid_valid_next;
  logic    out_valid_next;
  result_t skid_data;
  logic    pop;

  assign room = !skid_valid;
  assign pop  = out_valid && out_ready;

  always_comb begin
    out_valid_next  = out_valid;
    skid_valid_next = skid_valid;
    if (push) begin
      if (!out_valid || pop) begin
        out_valid_next = 1'b1;
      end else begin
        skid_valid_next = 1'b1;
      end
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid_next = 1'b0;
      end else begin
        out_valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && (!out_valid || pop)) begin
      out_data <= push_data;
    end else if (pop && skid_valid) begin
      out_data <= skid_data;
    end
    if (push && out_valid && !pop) begin
      skid_data <= push_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result while the output stage is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> room)
    else $error("result pushed while both stages are full");

endmodule
`default_nettype wire

// File: sv/stopwatch_with_key_lockout_unit.sv
// Top level of the stopwatch with key lockout: registers, core and result buffer.
//
//   Channel   Signals                               Direction  Carries
//   request   in_valid, in_ready, op, key_down      in         tick, frame or click
//   result    out_valid, out_ready, digits, zone    out        one per frame request
//   config    psel, penable, pwrite, paddr, pwdata  in         three limits, lockout frames
//
// Each request is taken while in_ready is high, and a new one may follow back to back.
// A frame request's result goes to the result register, or to the skid entry
// when it is full and not read. Ticks, clicks and the unused code give no result.
// Reset (synchronous) stops the stopwatch, clears the time and the lockout and
// loads the default limits. A stalled result sink holds the result register and
// one skid entry; in_ready falls only once both are occupied.
`default_nettype none
module stopwatch_with_key_lockout_unit (
  input  logic                              clk,
  input  logic                              rst,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [swkl_pkg::ApbAddrWidth-1:0] paddr,
  input  logic [swkl_pkg::ApbDataWidth-1:0] pwdata,
  output logic [swkl_pkg::ApbDataWidth-1:0] prdata,
  output logic                              pready,
  // Request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        op,
  input  logic                              key_down,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [3:0]                        min_tens,
  output logic [3:0]                        min_ones,
  output logic [2:0]                        sec_tens,
  output logic [3:0]                        sec_ones,
  output logic [3:0]                        tenth_digit,
  output logic [3:0]                        hundredth_digit,
  output logic [1:0]                        color_zone,
  output logic                              running
);
  import swkl_pkg::*;

  cfg_t    cfg;
  result_t core_result;
  result_t out_data;
  logic    push;
  logic    room;
  logic    in_fire;

  // The core only ever produces a result for a frame, and a request is taken
  // only while the skid entry is free, so no result can be lost.
  assign in_ready = room;
  assign in_fire  = in_valid && in_ready;

  swkl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  swkl_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .op       (op),
    .key_down (key_down),
    .cfg      (cfg),
    .push     (push),
    .result   (core_result)
  );

  swkl_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (core_result),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The result fields leave the block as separate ports.
  assign min_tens        = out_data.min_tens;
  assign min_ones        = out_data.min_ones;
  assign sec_tens        = out_data.sec_tens;
  assign sec_ones        = out_data.sec_ones;
  assign tenth_digit     = out_data.tenth_digit;
  assign hundredth_digit = out_data.hundredth_digit;
  assign color_zone      = out_data.color_zone;
  assign running         = out_data.running;

endmodule
`default_nettype wire
